FILE: rtl/reversible_deque_unit_assert.svh
// ----------------------------------------------------------------------------
// Reversible deque assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_UNIT_ASSERT_SVH
`define REVERSIBLE_DEQUE_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define RDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// Reversible deque package
// Shared types, codes and sizes for the reversible deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

    // Ring store size and derived widths
    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam int VALUE_W = 7;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;

    // Largest value a push may carry
    localparam logic [VALUE_W-1:0] MAX_VALUE = 7'd100;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd4;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_POPPED  = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_DONE    = 3'd2,
        ST_FULL    = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    // Work classes handed from the front to the back
    typedef enum logic [1:0] {
        K_POP,
        K_PUSH,
        K_REVERSE,
        K_REPORT
    } t_kind;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    // Command word in
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] push_value;
    } t_cmd_in;

    // Result word out
    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        logic [STAT_W-1:0]  status;
    } t_result;

    // Classified job
    typedef struct packed {
        t_kind              kind;
        logic               at_front;
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_job;

    // Job link between two stages
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_link;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

FILE: rtl/rdq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/rdq_front.sv
// ----------------------------------------------------------------------------
// Reversible deque front end
// Accepts command words, classifies them and holds one job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire rdq_pkg::t_cmd_in i_cmd,
    output      logic           o_busy,
    output      rdq_pkg::t_job_link o_link,
    input  wire logic           i_link_ready
);

    logic          r_valid;
    logic          n_valid;
    rdq_pkg::t_job r_job;
    rdq_pkg::t_job n_job;
    rdq_pkg::t_job w_class;
    logic          w_accept;
    logic          w_drain;

    // Classify the incoming command
    always_comb begin
        w_class.kind     = rdq_pkg::K_REPORT;
        w_class.at_front = 1'b0;
        w_class.value    = i_cmd.push_value;
        w_class.status   = rdq_pkg::ST_DONE;
        case (i_cmd.cmd)
            rdq_pkg::CMD_POP_BACK: begin
                w_class.kind = rdq_pkg::K_POP;
            end
            rdq_pkg::CMD_POP_FRONT: begin
                w_class.kind     = rdq_pkg::K_POP;
                w_class.at_front = 1'b1;
            end
            rdq_pkg::CMD_REVERSE: begin
                w_class.kind = rdq_pkg::K_REVERSE;
            end
            rdq_pkg::CMD_PUSH_BACK, rdq_pkg::CMD_PUSH_FRONT: begin
                if (i_cmd.push_value > rdq_pkg::MAX_VALUE) begin
                    w_class.status = rdq_pkg::ST_IGNORED;
                end else begin
                    w_class.kind     = rdq_pkg::K_PUSH;
                    w_class.at_front = (i_cmd.cmd == rdq_pkg::CMD_PUSH_FRONT);
                end
            end
            default: begin
                w_class.kind = rdq_pkg::K_REPORT;
            end
        endcase
    end

    // Hold off new words while the stage is full and cannot drain
    assign o_busy   = r_valid & ~i_link_ready;
    assign w_accept = i_start & ~o_busy;
    assign w_drain  = r_valid & i_link_ready;

    always_comb begin
        n_valid = w_accept | (r_valid & ~w_drain);
        n_job   = w_accept ? w_class : r_job;
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_link.valid = r_valid;
    assign o_link.job   = r_job;

endmodule

`default_nettype wire

FILE: rtl/rdq_queue.sv
// ----------------------------------------------------------------------------
// Reversible deque job queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rdq_pkg::t_job_link i_link,
    output      logic               o_ready,
    output      rdq_pkg::t_job_link o_link,
    input  wire logic               i_take
);

    rdq_pkg::t_job                   r_slot [rdq_pkg::QUEUE_DEPTH];
    logic [rdq_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [rdq_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [rdq_pkg::QUEUE_CW-1:0]    r_fill;
    logic [rdq_pkg::QUEUE_AW-1:0]    n_wr_ptr;
    logic [rdq_pkg::QUEUE_AW-1:0]    n_rd_ptr;
    logic [rdq_pkg::QUEUE_CW-1:0]    n_fill;
    logic                            w_push;
    logic                            w_pop;

    localparam logic [rdq_pkg::QUEUE_AW-1:0] LAST_SLOT =
        rdq_pkg::QUEUE_AW'(rdq_pkg::QUEUE_DEPTH - 1);

    assign o_ready = (r_fill != rdq_pkg::QUEUE_CW'(rdq_pkg::QUEUE_DEPTH));
    assign w_push  = i_link.valid & o_ready;
    assign w_pop   = i_take & (r_fill != '0);

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_link.job;
        end
    end

    assign o_link.valid = (r_fill != '0);
    assign o_link.job   = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/rdq_back.sv
// ----------------------------------------------------------------------------
// Reversible deque back end
// Executes jobs on the ring store and drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reversible_deque_unit_assert.svh"

module rdq_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rdq_pkg::t_job_link i_link,
    output      logic               o_take,
    output      logic               o_strobe,
    output      rdq_pkg::t_result   o_result
);

    localparam logic [rdq_pkg::ADDR_W-1:0] LAST_SLOT =
        rdq_pkg::ADDR_W'(rdq_pkg::DEPTH - 1);
    localparam logic [rdq_pkg::CNT_W-1:0]  FULL_COUNT =
        rdq_pkg::CNT_W'(rdq_pkg::DEPTH);
    localparam logic [rdq_pkg::SUM_W-1:0]  WRAP_SUM =
        rdq_pkg::SUM_W'(rdq_pkg::DEPTH);

    rdq_pkg::t_back_state          r_state;
    rdq_pkg::t_back_state          n_state;
    logic [rdq_pkg::ADDR_W-1:0]    r_head;
    logic [rdq_pkg::ADDR_W-1:0]    n_head;
    logic [rdq_pkg::CNT_W-1:0]     r_count;
    logic [rdq_pkg::CNT_W-1:0]     n_count;
    logic                          r_rev;
    logic                          n_rev;
    logic                          r_out_valid;
    logic                          n_out_valid;
    rdq_pkg::t_result              r_out;
    rdq_pkg::t_result              n_out;

    logic                          w_take;
    logic                          w_reading;
    logic                          w_at_head;
    logic [rdq_pkg::ADDR_W-1:0]    w_head_inc;
    logic [rdq_pkg::ADDR_W-1:0]    w_head_dec;
    logic [rdq_pkg::SUM_W-1:0]     w_sum_back;
    logic [rdq_pkg::SUM_W-1:0]     w_sum_last;
    logic [rdq_pkg::ADDR_W-1:0]    w_slot_back;
    logic [rdq_pkg::ADDR_W-1:0]    w_slot_last;

    logic                          w_we;
    logic [rdq_pkg::ADDR_W-1:0]    w_waddr;
    logic                          w_re;
    logic [rdq_pkg::ADDR_W-1:0]    w_raddr;
    logic [rdq_pkg::VALUE_W-1:0]   w_rdata;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdq_pkg::BK_IDLE: begin
                if (i_link.valid && i_link.job.kind == rdq_pkg::K_POP &&
                    r_count != '0) begin
                    n_state = rdq_pkg::BK_READ;
                end
            end
            rdq_pkg::BK_READ: begin
                n_state = rdq_pkg::BK_IDLE;
            end
            default: begin
                n_state = rdq_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        w_take    = 1'b0;
        w_reading = 1'b0;
        case (r_state)
            rdq_pkg::BK_IDLE: begin
                w_take = i_link.valid;
            end
            rdq_pkg::BK_READ: begin
                w_reading = 1'b1;
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
    end

    // Ring slot arithmetic
    always_comb begin
        w_head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
        w_head_dec  = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
        w_sum_back  = rdq_pkg::SUM_W'(r_head) + rdq_pkg::SUM_W'(r_count);
        w_sum_last  = w_sum_back - 1'b1;
        w_slot_back = (w_sum_back >= WRAP_SUM) ?
            rdq_pkg::ADDR_W'(w_sum_back - WRAP_SUM) : rdq_pkg::ADDR_W'(w_sum_back);
        w_slot_last = (w_sum_last >= WRAP_SUM) ?
            rdq_pkg::ADDR_W'(w_sum_last - WRAP_SUM) : rdq_pkg::ADDR_W'(w_sum_last);
        w_at_head   = i_link.job.at_front ^ r_rev;
    end

    // Execute the job at the head of the queue
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_rev       = r_rev;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = w_slot_back;
        w_re        = 1'b0;
        w_raddr     = r_head;

        if (w_reading) begin
            n_out_valid        = 1'b1;
            n_out.popped_value = w_rdata;
            n_out.status       = rdq_pkg::ST_POPPED;
        end

        if (w_take) begin
            n_out.popped_value = '0;
            case (i_link.job.kind)
                rdq_pkg::K_POP: begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = rdq_pkg::ST_EMPTY;
                    end else begin
                        w_re    = 1'b1;
                        n_count = r_count - 1'b1;
                        if (w_at_head) begin
                            n_head = w_head_inc;
                        end else begin
                            w_raddr = w_slot_last;
                        end
                    end
                end
                rdq_pkg::K_PUSH: begin
                    n_out_valid = 1'b1;
                    if (r_count == FULL_COUNT) begin
                        n_out.status = rdq_pkg::ST_FULL;
                    end else begin
                        w_we         = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_out.status = rdq_pkg::ST_DONE;
                        if (w_at_head) begin
                            n_head  = w_head_dec;
                            w_waddr = w_head_dec;
                        end
                    end
                end
                rdq_pkg::K_REVERSE: begin
                    n_out_valid  = 1'b1;
                    n_rev        = ~r_rev;
                    n_out.status = rdq_pkg::ST_DONE;
                end
                default: begin
                    n_out_valid  = 1'b1;
                    n_out.status = i_link.job.status;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdq_pkg::BK_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // Ring store
    rdq_ram #(
        .WIDTH (rdq_pkg::VALUE_W),
        .DEPTH (rdq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_link.job.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_take   = w_take;
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // Checks
    `RDQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_COUNT, "entry count above depth")
    `RDQ_ASSERT_NOW(a_head_bound, 1'b1, r_head <= LAST_SLOT, "head index outside ring")
    `RDQ_ASSERT_NEXT(a_read_result, r_state == rdq_pkg::BK_READ, o_strobe && o_result.status == rdq_pkg::ST_POPPED, "pop read gave no popped result")
    `RDQ_ASSERT_NEXT(a_push_count, w_take && i_link.job.kind == rdq_pkg::K_PUSH && r_count != FULL_COUNT, r_count == $past(r_count) + 1'b1, "push did not grow the count")

endmodule

`default_nettype wire

FILE: rtl/reversible_deque_unit.sv
// ----------------------------------------------------------------------------
// Reversible deque unit
// Bounded double-ended queue of 7-bit values with an order reverse command.
// ----------------------------------------------------------------------------
// A command word is taken on a clock edge with start high and busy low. Every
// command yields exactly one result word, shown for a single cycle with
// o_strobe high; the receiver cannot stall, so results must be captured as
// they appear. Results come out in command order. Each job passes the front
// stage register, the job queue and the result register of the back end; a
// pop from a non-empty queue also waits for the registered read of the ring
// store. The back end executes one push, reverse or report per cycle while no
// pop read is in progress, and a pop holds off the next job while it waits
// for that read; busy rises when the two-entry job queue and the front stage
// are both full. No clearing pass is needed after reset.
`default_nettype none

module reversible_deque_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire rdq_pkg::t_cmd_in i_cmd,
    output      logic             busy,
    output      logic             o_strobe,
    output      rdq_pkg::t_result o_result
);

    rdq_pkg::t_job_link w_front_link;
    rdq_pkg::t_job_link w_queue_link;
    logic               w_queue_ready;
    logic               w_take;

    // Accept and classify
    rdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .o_busy       (busy),
        .o_link       (w_front_link),
        .i_link_ready (w_queue_ready)
    );

    // Buffer jobs between front and back
    rdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_front_link),
        .o_ready (w_queue_ready),
        .o_link  (w_queue_link),
        .i_take  (w_take)
    );

    // Execute on the ring store
    rdq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_queue_link),
        .o_take   (w_take),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Reversible deque unit testbench
// Drives command words through the start/busy handshake and checks every
// strobed result against a cycle-free model of the ring store. The model
// covers head, count and direction flag. Runs directed empty-queue and
// ordering cases, a fill to capacity, and long random push/pop traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    // Command codes the block treats as no-ops
    localparam logic [rdq_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [rdq_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
    localparam int VALUE_TOP  = (1 << rdq_pkg::VALUE_W) - 1;
    localparam int QUIET_LIMIT = 1000;
    localparam int REPORT_MAX  = 10;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             start    = 1'b0;
    rdq_pkg::t_cmd_in cmd_word = '0;
    logic             busy;
    logic             o_strobe;
    rdq_pkg::t_result o_result;

    reversible_deque_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd_word),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Model of the ring store and its pointers
    logic [rdq_pkg::VALUE_W-1:0] ring [rdq_pkg::DEPTH];
    logic [rdq_pkg::ADDR_W-1:0]  head_idx   = '0;
    logic [rdq_pkg::CNT_W-1:0]   fill_count = '0;
    logic                        flipped    = 1'b0;

    // Results still owed by the block, oldest first
    rdq_pkg::t_result pending_results [$];
    int      in_flight   = 0;
    int      mismatches  = 0;
    int      quiet_cycles = 0;
    bit      steady      = 1'b0;

    // Coverage tallies for the summary
    int words_sent = 0;
    int n_popped   = 0;
    int n_empty    = 0;
    int n_full     = 0;
    int n_ignored  = 0;
    int n_reverse  = 0;
    int peak_fill  = 0;

    // Apply one command to the model and return the result it owes
    function automatic rdq_pkg::t_result deque_outcome(input rdq_pkg::t_cmd_in w);
        rdq_pkg::t_result res;
        logic             at_head;
        res = '0;
        res.status = rdq_pkg::ST_DONE;
        case (w.cmd)
            rdq_pkg::CMD_POP_BACK, rdq_pkg::CMD_POP_FRONT: begin
                at_head = (w.cmd == rdq_pkg::CMD_POP_FRONT) != flipped;
                if (fill_count == 0) begin
                    res.status = rdq_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    if (at_head) begin
                        res.popped_value = ring[head_idx];
                        head_idx = head_idx + 1'b1;
                    end else begin
                        res.popped_value =
                            ring[rdq_pkg::ADDR_W'(head_idx + fill_count - 1)];
                    end
                    fill_count = fill_count - 1'b1;
                    res.status = rdq_pkg::ST_POPPED;
                    n_popped++;
                end
            end
            rdq_pkg::CMD_REVERSE: begin
                flipped = !flipped;
                n_reverse++;
            end
            rdq_pkg::CMD_PUSH_BACK, rdq_pkg::CMD_PUSH_FRONT: begin
                at_head = (w.cmd == rdq_pkg::CMD_PUSH_FRONT) != flipped;
                if (w.push_value > rdq_pkg::MAX_VALUE) begin
                    res.status = rdq_pkg::ST_IGNORED;
                    n_ignored++;
                end else if (fill_count >= rdq_pkg::DEPTH) begin
                    res.status = rdq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    if (at_head) begin
                        head_idx = head_idx - 1'b1;
                        ring[head_idx] = w.push_value;
                    end else begin
                        ring[rdq_pkg::ADDR_W'(head_idx + fill_count)] = w.push_value;
                    end
                    fill_count = fill_count + 1'b1;
                    if (fill_count > peak_fill) peak_fill = fill_count;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic rdq_pkg::t_cmd_in make_word(
        input logic [rdq_pkg::CMD_W-1:0]   c,
        input logic [rdq_pkg::VALUE_W-1:0] v);
        rdq_pkg::t_cmd_in w;
        w.cmd = c;
        w.push_value = v;
        return w;
    endfunction

    // Hold the word on the bus until the block takes it, then log the result owed
    task automatic send_word(input rdq_pkg::t_cmd_in w);
        int               gap;
        rdq_pkg::t_cmd_in noise;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            noise.cmd = rdq_pkg::CMD_W'($urandom);
            noise.push_value = rdq_pkg::VALUE_W'($urandom);
            start <= 1'b0;
            cmd_word <= noise;
            repeat (gap) @(posedge i_clk);
        end
        if (start !== 1'b1) start <= 1'b1;
        cmd_word <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.insert(pending_results.size(), deque_outcome(w));
        in_flight++;
        words_sent++;
    endtask

    // Drop start and hold off until every owed result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        wait (in_flight == 0);
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input rdq_pkg::t_result want,
                                   input rdq_pkg::t_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
                     $realtime, what, want.popped_value, want.status,
                     got.popped_value, got.status);
    endtask

    // Check each strobed result against the oldest owed one
    always @(posedge i_clk) begin
        rdq_pkg::t_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing owed", '0, o_result);
            end else begin
                want = pending_results.pop_front();
                in_flight--;
                if (o_strobe !== 1'b1 || o_result.popped_value !== want.popped_value)
                    report_mismatch("popped value", want, o_result);
                else if (o_result.status !== want.status)
                    report_mismatch("status", want, o_result);
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1 || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Pops on an empty queue, reverse with nothing in it, spare command codes
    task automatic test_empty_queue();
        send_word(make_word(rdq_pkg::CMD_POP_BACK, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd127));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd127));
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_word(make_word(rdq_pkg::CMD_W'(c), 7'd100));
        wait_for_results();
    endtask

    // Both ends in both directions, value limits and ignored values
    task automatic test_push_and_order();
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd0));
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd100));
        send_word(make_word(rdq_pkg::CMD_PUSH_FRONT, 7'd127));
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd101));
        send_word(make_word(rdq_pkg::CMD_PUSH_FRONT, 7'd85));
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd42));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_PUSH_FRONT, 7'd7));
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd99));
        send_word(make_word(rdq_pkg::CMD_POP_BACK, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_BACK, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_POP_BACK, 7'd0));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd0));
        wait_for_results();
    endtask

    // Fill the store, push against it from both sides, then drain it
    task automatic test_fill_to_capacity();
        logic [rdq_pkg::CMD_W-1:0] c;
        while (fill_count < rdq_pkg::DEPTH) begin
            c = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT;
            send_word(make_word(c,
                rdq_pkg::VALUE_W'($urandom_range(0, rdq_pkg::MAX_VALUE))));
        end
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd55));
        send_word(make_word(rdq_pkg::CMD_PUSH_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_PUSH_FRONT, 7'd120));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd0));
        send_word(make_word(rdq_pkg::CMD_PUSH_BACK, 7'd100));
        wait_for_results();
        while (fill_count > 0) begin
            c = $urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK : rdq_pkg::CMD_POP_FRONT;
            send_word(make_word(c, rdq_pkg::VALUE_W'($urandom)));
        end
        send_word(make_word(rdq_pkg::CMD_POP_FRONT, 7'd0));
        send_word(make_word(rdq_pkg::CMD_REVERSE, 7'd0));
        wait_for_results();
    endtask

    // Random walk between empty and full, switching bias at each extreme
    task automatic test_random_traffic(input int n_words);
        bit                          filling;
        int                          r;
        logic [rdq_pkg::CMD_W-1:0]   c;
        logic [rdq_pkg::VALUE_W-1:0] v;
        filling = 1'b1;
        for (int i = 0; i < n_words; i++) begin
            if (filling && fill_count == rdq_pkg::DEPTH && $urandom_range(0, 7) == 0)
                filling = 1'b0;
            else if (!filling && fill_count == 0 && $urandom_range(0, 7) == 0)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            v = rdq_pkg::VALUE_W'($urandom_range(0, VALUE_TOP));
            if (r < 4) begin
                c = rdq_pkg::CMD_REVERSE;
            end else if (r < 6) begin
                c = rdq_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            end else if (r < 10) begin
                c = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT;
                v = rdq_pkg::VALUE_W'($urandom_range(rdq_pkg::MAX_VALUE + 1, VALUE_TOP));
            end else if ($urandom_range(0, 99) < (filling ? 80 : 20)) begin
                c = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT;
                v = rdq_pkg::VALUE_W'($urandom_range(0, rdq_pkg::MAX_VALUE));
            end else begin
                c = $urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK : rdq_pkg::CMD_POP_FRONT;
            end
            send_word(make_word(c, v));
            // hold off now and then until the block has caught up
            if (i % 250 == 249) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_push_and_order();
        test_fill_to_capacity();
        test_random_traffic(1100);

        // let any stray result show before the verdict
        repeat (8) @(posedge i_clk);
        $display("Sent %0d words: %0d pops, %0d empty pops, %0d full drops, %0d ignored values",
                 words_sent, n_popped, n_empty, n_full, n_ignored);
        $display("Reversed order %0d times, peak occupancy %0d of %0d",
                 n_reverse, peak_fill, rdq_pkg::DEPTH);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, pending_results.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
